FILE: src/ptt_pkg.sv
// Shared types and constants of the periodic task timer table.
// Depends on nothing; imported by the channel interfaces and all modules.
`default_nettype none

package ptt_pkg;

   // Fixed field widths of the request and response items
   localparam int TYPE_W        = 2;
   localparam int PERIOD_W      = 32;
   localparam int SLOT_FIELD_W  = 4;
   localparam int COUNT_FIELD_W = 5;
   localparam int TIME_W        = 64;

   // At most this many due results are emitted by one tick
   localparam int MAX_RESULTS   = 16;
   localparam int RUN_W         = $clog2(MAX_RESULTS + 1);

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd2;

   // Result kinds
   localparam logic [TYPE_W-1:0] KIND_ADD_ACK    = 2'd0;
   localparam logic [TYPE_W-1:0] KIND_REMOVE_ACK = 2'd1;
   localparam logic [TYPE_W-1:0] KIND_DUE        = 2'd2;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // One entry of the slot memory
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   due_time;
   } slot_entry_type;

endpackage : ptt_pkg

`default_nettype wire

FILE: src/ptt_if.sv
// Valid/ready channel interfaces for requests and responses of the timer table.
// Depends on ptt_pkg for field widths.
`default_nettype none

interface ptt_req_if
   import ptt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [PERIOD_W-1:0] period_ms;
   logic [3:0]          target_slot;

   modport source (output valid, output req_type, output period_ms, output target_slot,
                   input ready);
   modport sink   (input valid, input req_type, input period_ms, input target_slot,
                   output ready);
endinterface : ptt_req_if

interface ptt_rsp_if
   import ptt_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [TYPE_W-1:0]        result_kind;
   logic [SLOT_FIELD_W-1:0]  slot_id;
   logic                     status;
   logic [COUNT_FIELD_W-1:0] active_count;
   logic                     last_of_run;

   modport source (output valid, output result_kind, output slot_id, output status,
                   output active_count, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input slot_id, input status,
                   input active_count, input last_of_run, output ready);
endinterface : ptt_rsp_if

`default_nettype wire

FILE: src/periodic_task_timer_table_unit.sv
// Periodic task timer table, top level. Uses ptt_pkg, ptt_if and ptt_slot_ram.
// Remove loads its result from the S_ACK state; add first steps the free-slot search
// through S_ADD, one valid bit per cycle, then S_ACK; tick scans in S_TICK, reading one
// memory entry per cycle unless a response stall holds the scan, and ends in S_FLUSH.
// One request in work at a time; the next is taken the cycle after the last result loads or S_FLUSH.
// Synchronous active-high reset clears time, valid bits and task count; no memory clearing.
`default_nettype none

module periodic_task_timer_table_unit
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ptt_req_if.sink     req_chan,
   ptt_rsp_if.source   rsp_chan
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam int TGT_W = (IDX_W > 4) ? IDX_W : 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_ACK,
      S_TICK,
      S_FLUSH
   } state_type;

   // Control state
   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic                  issue_act_ff, issue_act_in;
   logic [RUN_W-1:0]      run_ff, run_in;

   // Payload and index registers
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]         issue_idx_ff, issue_idx_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic [TYPE_W-1:0]        ack_kind_ff, ack_kind_in;
   logic [SLOT_FIELD_W-1:0]  ack_slot_ff, ack_slot_in;
   logic                     ack_status_ff, ack_status_in;
   logic [TYPE_W-1:0]        out_kind_ff, out_kind_in;
   logic [SLOT_FIELD_W-1:0]  out_slot_ff, out_slot_in;
   logic                     out_status_ff, out_status_in;
   logic [COUNT_FIELD_W-1:0] out_count_ff, out_count_in;
   logic                     out_last_ff, out_last_in;

   // Memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_entry_type   wr_data;
   logic [IDX_W-1:0] rd_addr;
   slot_entry_type   rd_data;

   logic             req_fire;
   logic             out_free;
   logic             hit;
   logic             stall;
   logic [TGT_W-1:0] tgt_wide;
   logic [IDX_W-1:0] tgt_idx;
   logic             tgt_in_range;

   ptt_slot_ram #(
      .DEPTH (NUM_SLOTS),
      .AW    (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Take a request only between requests; a finished response may still wait.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The output register can load when empty or when its transfer completes now.
   assign out_free = !out_vld_ff || rsp_chan.ready;

   assign tgt_wide     = TGT_W'(req_chan.target_slot);
   assign tgt_idx      = IDX_W'(tgt_wide);
   assign tgt_in_range = 32'(req_chan.target_slot) < NUM_SLOTS;

   // Check stage of the tick scan: entry chk_idx_ff sits in rd_data this cycle.
   assign hit   = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_data.due_time <= now_ff);
   // A second hit must push the held one out first; hold the scan if it cannot.
   assign stall = hit && pend_vld_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      out_vld_in    = out_vld_ff;
      pend_vld_in   = pend_vld_ff;
      chk_vld_in    = chk_vld_ff;
      issue_act_in  = issue_act_ff;
      run_in        = run_ff;
      scan_idx_in   = scan_idx_ff;
      issue_idx_in  = issue_idx_ff;
      chk_idx_in    = chk_idx_ff;
      pend_idx_in   = pend_idx_ff;
      period_in     = period_ff;
      ack_kind_in   = ack_kind_ff;
      ack_slot_in   = ack_slot_ff;
      ack_status_in = ack_status_ff;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;

      wr_en            = 1'b0;
      wr_addr          = scan_idx_ff;
      wr_data.period   = period_ff;
      wr_data.due_time = now_ff + TIME_W'(period_ff);
      rd_addr          = issue_idx_ff;

      // Drop the response once its transfer completes
      if (out_vld_ff && rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.req_type)
                  REQ_ADD: begin
                     period_in   = req_chan.period_ms;
                     scan_idx_in = '0;
                     state_in    = S_ADD;
                  end
                  REQ_REMOVE: begin
                     ack_kind_in = KIND_REMOVE_ACK;
                     ack_slot_in = req_chan.target_slot;
                     if (tgt_in_range && valid_ff[tgt_idx]) begin
                        valid_in[tgt_idx] = 1'b0;
                        total_in          = total_ff - 1'b1;
                        ack_status_in     = STATUS_OK;
                     end else begin
                        ack_status_in     = STATUS_FAIL;
                     end
                     state_in = S_ACK;
                  end
                  REQ_TICK: begin
                     // Advance time first; the scan compares against the new time
                     now_in       = now_ff + 1'b1;
                     issue_idx_in = '0;
                     issue_act_in = 1'b1;
                     chk_vld_in   = 1'b0;
                     pend_vld_in  = 1'b0;
                     run_in       = '0;
                     state_in     = S_TICK;
                  end
                  default: begin
                     // Unused code: no result, no state change
                  end
               endcase
            end
         end

         S_ADD: begin
            // Claim the lowest free slot, one valid bit per cycle
            if (!valid_ff[scan_idx_ff]) begin
               valid_in[scan_idx_ff] = 1'b1;
               wr_en         = 1'b1;
               wr_addr       = scan_idx_ff;
               total_in      = total_ff + 1'b1;
               ack_kind_in   = KIND_ADD_ACK;
               ack_slot_in   = SLOT_FIELD_W'(scan_idx_ff);
               ack_status_in = STATUS_OK;
               state_in      = S_ACK;
            end else if (scan_idx_ff == LAST_IDX) begin
               ack_kind_in   = KIND_ADD_ACK;
               ack_slot_in   = '0;
               ack_status_in = STATUS_FAIL;
               state_in      = S_ACK;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         S_ACK: begin
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_kind_in   = ack_kind_ff;
               out_slot_in   = ack_slot_ff;
               out_status_in = ack_status_ff;
               out_count_in  = COUNT_FIELD_W'(total_in);
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_TICK: begin
            if (stall) begin
               // Re-read the entry under check so rd_data holds it
               rd_addr = chk_idx_ff;
            end else begin
               if (hit) begin
                  // Re-arm the due slot; any read this cycle that is still needed is a different entry
                  wr_en            = 1'b1;
                  wr_addr          = chk_idx_ff;
                  wr_data.period   = rd_data.period;
                  wr_data.due_time = now_ff + TIME_W'(rd_data.period);
                  run_in           = run_ff + 1'b1;
                  if (pend_vld_ff) begin
                     out_vld_in    = 1'b1;
                     out_kind_in   = KIND_DUE;
                     out_slot_in   = SLOT_FIELD_W'(pend_idx_ff);
                     out_status_in = STATUS_OK;
                     out_count_in  = COUNT_FIELD_W'(total_ff);
                     out_last_in   = 1'b0;
                  end
                  // Hold the newest hit until it is known whether it is the last
                  pend_vld_in = 1'b1;
                  pend_idx_in = chk_idx_ff;
               end

               if (chk_vld_ff && ((chk_idx_ff == LAST_IDX) ||
                                  (hit && (run_ff == RUN_W'(MAX_RESULTS - 1))))) begin
                  chk_vld_in   = 1'b0;
                  issue_act_in = 1'b0;
                  state_in     = S_FLUSH;
               end else begin
                  // Advance the scan: the entry read now is checked next cycle
                  chk_vld_in = issue_act_ff;
                  chk_idx_in = issue_idx_ff;
                  if (issue_act_ff) begin
                     if (issue_idx_ff == LAST_IDX) begin
                        issue_act_in = 1'b0;
                     end else begin
                        issue_idx_in = issue_idx_ff + 1'b1;
                     end
                  end
               end
            end
         end

         S_FLUSH: begin
            // Emit the held hit, if any, as the final result of this tick
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_vld_in    = 1'b1;
               out_kind_in   = KIND_DUE;
               out_slot_in   = SLOT_FIELD_W'(pend_idx_ff);
               out_status_in = STATUS_OK;
               out_count_in  = COUNT_FIELD_W'(total_ff);
               out_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         out_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         issue_act_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         out_vld_ff   <= out_vld_in;
         pend_vld_ff  <= pend_vld_in;
         chk_vld_ff   <= chk_vld_in;
         issue_act_ff <= issue_act_in;
         run_ff       <= run_in;
      end
      scan_idx_ff   <= scan_idx_in;
      issue_idx_ff  <= issue_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pend_idx_ff   <= pend_idx_in;
      period_ff     <= period_in;
      ack_kind_ff   <= ack_kind_in;
      ack_slot_ff   <= ack_slot_in;
      ack_status_ff <= ack_status_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.result_kind  = out_kind_ff;
   assign rsp_chan.slot_id      = out_slot_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.active_count = out_count_ff;
   assign rsp_chan.last_of_run  = out_last_ff;

endmodule : periodic_task_timer_table_unit

`default_nettype wire

FILE: src/ptt_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on ptt_pkg for the entry type.
`default_nettype none

module ptt_slot_ram
   import ptt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire slot_entry_type wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   output slot_entry_type      rd_data
);

   slot_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : ptt_slot_ram

`default_nettype wire

FILE: verif/timer_table_checker.sv
// Checker for the periodic task timer table: watches the request and response
// channels, predicts every response and compares it field by field.
// Depends on ptt_pkg and the ptt_req_if / ptt_rsp_if channel interfaces.
`default_nettype none

module timer_table_checker
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ptt_req_if        req_chan,
   ptt_rsp_if        rsp_chan,
   output int        error_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TYPE_W-1:0]        kind;
      logic [SLOT_FIELD_W-1:0]  slot;
      logic                     status;
      logic [COUNT_FIELD_W-1:0] count;
      logic                     last;
   } timer_result_type;

   // Predicted copy of the timer table
   logic [TIME_W-1:0]        clock_ms;
   logic                     slot_live   [NUM_SLOTS];
   logic [PERIOD_W-1:0]      slot_period [NUM_SLOTS];
   logic [TIME_W-1:0]        slot_due    [NUM_SLOTS];
   logic [COUNT_FIELD_W-1:0] live_count;

   timer_result_type awaited_results[$];

   function automatic timer_result_type make_result(input logic [TYPE_W-1:0] kind,
                                                    input int slot,
                                                    input logic status, input logic last);
      timer_result_type r;
      r.kind   = kind;
      r.slot   = SLOT_FIELD_W'(slot);
      r.status = status;
      r.count  = live_count;
      r.last   = last;
      return r;
   endfunction

   // append one predicted result at the tail
   task automatic queue_result(input timer_result_type r);
      awaited_results.insert(awaited_results.size(), r);
   endtask

   task automatic apply_timer_request(input logic [TYPE_W-1:0] code,
                                      input logic [PERIOD_W-1:0] period,
                                      input logic [3:0] target);
      timer_result_type fired [MAX_RESULTS];
      int               fired_n;
      bit               placed;
      fired_n = 0;
      placed  = 1'b0;
      case (code)
         REQ_ADD: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!placed && !slot_live[i]) begin
                  slot_live[i]   = 1'b1;
                  slot_period[i] = period;
                  slot_due[i]    = clock_ms + TIME_W'(period);
                  live_count     = live_count + 1'b1;
                  placed         = 1'b1;
                  queue_result(make_result(KIND_ADD_ACK, i, STATUS_OK, 1'b1));
               end
            end
            if (!placed)
               queue_result(make_result(KIND_ADD_ACK, 0, STATUS_FAIL, 1'b1));
         end
         REQ_REMOVE: begin
            if (int'(target) < NUM_SLOTS && slot_live[target]) begin
               slot_live[target] = 1'b0;
               live_count        = live_count - 1'b1;
               queue_result(make_result(KIND_REMOVE_ACK, int'(target), STATUS_OK, 1'b1));
            end else begin
               queue_result(make_result(KIND_REMOVE_ACK, int'(target), STATUS_FAIL, 1'b1));
            end
         end
         REQ_TICK: begin
            clock_ms = clock_ms + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (fired_n < MAX_RESULTS && slot_live[i] && slot_due[i] <= clock_ms) begin
                  slot_due[i]     = clock_ms + TIME_W'(slot_period[i]);
                  fired[fired_n]  = make_result(KIND_DUE, i, STATUS_OK, 1'b0);
                  fired_n++;
               end
            end
            for (int k = 0; k < fired_n; k++) begin
               if (k == fired_n - 1)
                  fired[k].last = 1'b1;
               queue_result(fired[k]);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [4:0] want,
                                input logic [4:0] seen);
      if (seen !== want) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      end
   endtask

   task automatic check_result();
      timer_result_type seen;
      timer_result_type want;
      seen.kind   = rsp_chan.result_kind;
      seen.slot   = rsp_chan.slot_id;
      seen.status = rsp_chan.status;
      seen.count  = rsp_chan.active_count;
      seen.last   = rsp_chan.last_of_run;
      if (awaited_results.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                  $time, seen.kind, seen.slot);
      end else begin
         want = awaited_results.pop_front();
         compare_field("result_kind", 5'(want.kind), 5'(seen.kind));
         compare_field("slot_id", 5'(want.slot), 5'(seen.slot));
         compare_field("status", 5'(want.status), 5'(seen.status));
         compare_field("active_count", want.count, seen.count);
         compare_field("last_of_run", 5'(want.last), 5'(seen.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clock_ms    = '0;
         live_count  = '0;
         error_count = 0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_period[i] = '0;
            slot_due[i]    = '0;
         end
         awaited_results.delete();
      end else begin
         // retire the response first so a transfer on both sides stays in order
         if (rsp_chan.valid && rsp_chan.ready)
            check_result();
         if (req_chan.valid && req_chan.ready)
            apply_timer_request(req_chan.req_type, req_chan.period_ms, req_chan.target_slot);
      end
      pending_count <= awaited_results.size();
   end

endmodule : timer_table_checker

`default_nettype wire

FILE: verif/testbench.sv
// Top of the timer table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on ptt_pkg, the channel interfaces,
// timer_table_checker and periodic_task_timer_table_unit.
`default_nettype none

module testbench;
   import ptt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS = 16;
   localparam int CYCLE_LIMIT = 200000;
   // request code the block must drop without a response
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic steady_phase;
   int   cycle_count;
   int   error_count;
   int   pending_count;

   ptt_req_if req_chan();
   ptt_rsp_if rsp_chan();

   periodic_task_timer_table_unit #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   timer_table_checker #(.NUM_SLOTS(NUM_SLOTS)) table_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort the run if the block hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Response side: drop ready at random with a chance of 29 in 100, never during the steady phase.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= steady_phase || ($urandom_range(0, 99) >= 29);
      end
   end

   // Present one request, hold it until the transfer, then maybe idle a few cycles.
   // Valid stays high across back-to-back items, so it is only lowered in a gap.
   task automatic send_request(input logic [TYPE_W-1:0] code,
                               input logic [PERIOD_W-1:0] period,
                               input logic [3:0] target);
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= code;
      req_chan.period_ms   <= period;
      req_chan.target_slot <= target;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (!steady_phase) begin
         while ($urandom_range(0, 99) < 29) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold off until every predicted response has come back.
   // Wait for the clock first, so the checker has counted the last transfer.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // Random traffic: mostly ticks and adds with short intervals so slots keep
   // firing and the table fills up; removes hit live and free slots alike.
   // Unused codes are mixed in as noise and do not count toward the run.
   task automatic send_random_run(input int count);
      int                  made;
      int                  pick;
      int                  span;
      logic [PERIOD_W-1:0] period;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         span = $urandom_range(0, 9);
         if (span < 7)
            period = PERIOD_W'($urandom_range(0, 6));
         else if (span < 9)
            period = PERIOD_W'($urandom_range(7, 40));
         else
            period = $urandom;
         if (pick < 40) begin
            send_request(REQ_TICK, $urandom, 4'($urandom_range(0, 15)));
            made++;
         end else if (pick < 65) begin
            send_request(REQ_ADD, period, 4'($urandom_range(0, 15)));
            made++;
         end else if (pick < 95) begin
            send_request(REQ_REMOVE, $urandom, 4'($urandom_range(0, 15)));
            made++;
         end else begin
            send_request(REQ_UNUSED, $urandom, 4'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      steady_phase         <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= REQ_TICK;
      req_chan.period_ms   <= '0;
      req_chan.target_slot <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table tick, free remove, dropped code, then fill the
      // table, overflow it and fire every slot in a single tick.
      send_request(REQ_TICK, '0, '0);
      send_request(REQ_REMOVE, '0, 4'd0);
      send_request(REQ_UNUSED, '1, 4'hF);
      send_request(REQ_ADD, '0, '0);             // zero interval: due on every tick
      send_request(REQ_TICK, '0, '0);
      send_request(REQ_ADD, '1, '0);             // longest interval: never due here
      for (int i = 2; i < NUM_SLOTS; i++)
         send_request(REQ_ADD, '0, 4'(i));
      send_request(REQ_ADD, 32'd7, '0);          // table full
      send_request(REQ_TICK, '0, '0);            // all slots but one due
      send_request(REQ_REMOVE, '0, 4'd1);
      send_request(REQ_ADD, '0, '0);             // refill the freed slot
      send_request(REQ_TICK, '0, '0);            // every slot due at once
      drain_responses();

      // Random: a gappy run, a stretch with no idling, a full drain, then more.
      send_random_run(30);
      steady_phase <= 1'b1;
      send_random_run(25);
      steady_phase <= 1'b0;
      drain_responses();
      send_random_run(20);

      // Wait out the responses, then give the last tick time to settle.
      drain_responses();
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : testbench

`default_nettype wire
